>>> rtl/i2a_pkg.sv
// ----------------------------------------------------------------------------
// i2a_pkg: shared types and constants of the integer to ASCII formatter
// Request and result payloads, controller/datapath command and status
// structs, character codes and the digit-to-ASCII mapping.
// ----------------------------------------------------------------------------
package i2a_pkg;

  localparam int unsigned ValueW    = 64;
  localparam int unsigned NumDigits = 20;               // BCD digits held
  localparam int unsigned DigitsW   = 4 * NumDigits;
  localparam int unsigned NdigW     = $clog2(NumDigits + 1);
  localparam int unsigned StepW     = $clog2(ValueW);

  localparam logic [7:0] CharZero  = 8'h30;            // '0'
  localparam logic [7:0] CharLowA  = 8'h61;            // 'a'
  localparam logic [7:0] CharMinus = 8'h2d;            // '-'
  localparam logic [7:0] CharSpace = 8'h20;            // ' '
  localparam logic [3:0] DecBase   = 4'd10;

  // one request: a number and its format
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              signed_mode;
    logic              hex_mode;
    logic [7:0]        pad_width;
    logic              pad_with_zero;
  } i2a_in_t;

  // one result: one character of the field
  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
    logic [7:0] field_length;
  } i2a_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic conv_step;
    logic norm_step;
    logic calc;
    logic emit;
  } i2a_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hex;
    logic norm_done;
    logic out_free;
    logic emit_last;
  } i2a_status_t;

  // digit value to lower-case ASCII
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < DecBase) c = CharZero + {4'b0, d};
    else             c = CharLowA + {4'b0, d - DecBase};
    return c;
  endfunction

endpackage

>>> rtl/i2a_in_if.sv
// ----------------------------------------------------------------------------
// i2a_in_if: request channel of the formatter
// Valid/ready handshake carrying one number and its format.
// ----------------------------------------------------------------------------
interface i2a_in_if;
  logic              valid;
  logic              ready;
  i2a_pkg::i2a_in_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/i2a_out_if.sv
// ----------------------------------------------------------------------------
// i2a_out_if: character channel of the formatter
// Valid/ready handshake carrying one ASCII character per transfer.
// ----------------------------------------------------------------------------
interface i2a_out_if;
  logic              valid;
  logic              ready;
  i2a_pkg::i2a_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/i2a_datapath.sv
// ----------------------------------------------------------------------------
// i2a_datapath: conversion and character datapath
// Holds the magnitude, a double-dabble BCD register, digit count, field
// counters and the output register; acts on controller commands.
// ----------------------------------------------------------------------------
module i2a_datapath #(
  parameter int unsigned BUFFER_BYTES = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  i2a_pkg::i2a_in_t      in_data_i,
  input  i2a_pkg::i2a_cmd_t     cmd_i,
  output i2a_pkg::i2a_status_t  status_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output i2a_pkg::i2a_out_t     out_data_o
);
  import i2a_pkg::*;

  localparam int unsigned CntW   = $clog2(BUFFER_BYTES);
  localparam logic [7:0]  Limit8 = 8'(BUFFER_BYTES - 1);

  logic [ValueW-1:0]  mag_q,  mag_d;
  logic [DigitsW-1:0] dig_q,  dig_d;
  logic [NdigW-1:0]   ndig_q, ndig_d;
  logic               neg_q, hex_q, padz_q;
  logic [7:0]         width_q, total_q;
  logic [CntW-1:0]    pad_left_q, body_left_q;
  logic               sign_q;
  logic               out_valid_q;
  i2a_out_t           out_data_q;

  logic [ValueW-1:0]  load_mag;
  logic [DigitsW-1:0] dig_adj;
  logic [7:0]         len8, pads8, room8, body8, total8;
  logic               last_w;
  logic [7:0]         char_w;

  // magnitude of the incoming number
  always_comb begin
    load_mag = in_data_i.value;
    if (in_data_i.signed_mode && in_data_i.value[ValueW-1]) begin
      load_mag = ValueW'(0) - in_data_i.value;
    end
  end

  // double-dabble correction: add 3 to every BCD digit of 5 or more
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      dig_adj[4*i +: 4] = (dig_q[4*i +: 4] >= 4'd5) ? dig_q[4*i +: 4] + 4'd3
                                                     : dig_q[4*i +: 4];
    end
  end

  // field geometry: pads, kept body characters, full length
  always_comb begin
    len8   = 8'(ndig_q) + {7'b0, neg_q};
    total8 = (len8 > width_q) ? len8 : width_q;
    pads8  = (width_q > len8) ? width_q - len8 : 8'd0;
    if (pads8 > Limit8) pads8 = Limit8;
    room8  = Limit8 - pads8;
    body8  = (len8 > room8) ? room8 : len8;
  end

  // current character and end-of-field flag
  always_comb begin
    last_w = ((pad_left_q == CntW'(1)) && (body_left_q == '0)) ||
             ((pad_left_q == '0) && (body_left_q == CntW'(1)));
    if (pad_left_q != '0)  char_w = padz_q ? CharZero : CharSpace;
    else if (sign_q)       char_w = CharMinus;
    else                   char_w = digit_char(dig_q[DigitsW-1 -: 4]);
  end

  // next values of the working registers
  always_comb begin
    mag_d  = mag_q;
    dig_d  = dig_q;
    ndig_d = ndig_q;
    if (cmd_i.load) begin
      mag_d  = load_mag;
      dig_d  = in_data_i.hex_mode ? DigitsW'(load_mag) : '0;
      ndig_d = NdigW'(NumDigits);
    end else if (cmd_i.conv_step) begin
      dig_d = {dig_adj[DigitsW-2:0], mag_q[ValueW-1]};
      mag_d = {mag_q[ValueW-2:0], 1'b0};
    end else if (cmd_i.norm_step) begin
      dig_d  = {dig_q[DigitsW-5:0], 4'h0};
      ndig_d = ndig_q - NdigW'(1);
    end else if (cmd_i.emit && pad_left_q == '0 && !sign_q) begin
      dig_d = {dig_q[DigitsW-5:0], 4'h0};
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    dig_q  <= dig_d;
    ndig_q <= ndig_d;
    if (cmd_i.load) begin
      neg_q   <= in_data_i.signed_mode && in_data_i.value[ValueW-1];
      hex_q   <= in_data_i.hex_mode;
      padz_q  <= in_data_i.pad_with_zero;
      width_q <= in_data_i.pad_width;
    end
    if (cmd_i.calc) begin
      pad_left_q  <= CntW'(pads8);
      body_left_q <= CntW'(body8);
      sign_q      <= neg_q;
      total_q     <= total8;
    end else if (cmd_i.emit) begin
      if (pad_left_q != '0) begin
        pad_left_q <= pad_left_q - CntW'(1);
      end else begin
        body_left_q <= body_left_q - CntW'(1);
        sign_q      <= 1'b0;
      end
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q.out_char     <= char_w;
      out_data_q.last_char    <= last_w;
      out_data_q.field_length <= last_w ? total_q : 8'd0;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.hex       = hex_q;
  assign status_o.norm_done = (ndig_q == NdigW'(1)) || (dig_q[DigitsW-1 -: 4] != 4'h0);
  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign status_o.emit_last = last_w;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> rtl/i2a_ctrl.sv
// ----------------------------------------------------------------------------
// i2a_ctrl: formatter sequencer
// Walks each request through load, binary-to-BCD conversion (decimal only),
// leading-zero strip, field sizing and character emission.
// ----------------------------------------------------------------------------
module i2a_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  i2a_pkg::i2a_status_t  status_i,
  output i2a_pkg::i2a_cmd_t     cmd_o
);
  import i2a_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_CALC,
    ST_EMIT
  } state_e;

  state_e          state_q;
  logic [StepW-1:0] step_q;

  // commands from the current state
  always_comb begin
    cmd_o           = '0;
    in_ready_o      = (state_q == ST_IDLE);
    cmd_o.load      = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.conv_step = (state_q == ST_CONV) && !status_i.hex;
    cmd_o.norm_step = (state_q == ST_NORM) && !status_i.norm_done;
    cmd_o.calc      = (state_q == ST_CALC);
    cmd_o.emit      = (state_q == ST_EMIT) && status_i.out_free;
  end

  // state and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          step_q <= '0;
          if (in_valid_i) state_q <= ST_CONV;
        end
        ST_CONV: begin
          if (status_i.hex) begin
            state_q <= ST_NORM;
          end else begin
            step_q <= step_q + StepW'(1);
            if (step_q == StepW'(ValueW - 1)) state_q <= ST_NORM;
          end
        end
        ST_NORM: begin
          if (status_i.norm_done) state_q <= ST_CALC;
        end
        ST_CALC: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (status_i.out_free && status_i.emit_last) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/integer_to_ascii_formatter.sv
// Sequence: accept, one double-dabble shift per magnitude bit in decimal (none
//   in hex), one strip step per leading zero digit stripped, field sizing, then
//   one character per cycle while the output register is free or being drained.
// Throughput: one request in flight; the next is taken after its last
//   character enters the output register (the sequencer accepts only when idle).
// Reset: asynchronous, active low; clears the sequencer and output valid.
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter: 64-bit integer to decimal/hex ASCII text
// Formats a number with optional sign and left padding, one character per
// result, cut to BUFFER_BYTES-1 characters.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter #(
  parameter int unsigned BUFFER_BYTES = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  i2a_in_if.sink           in_i,
  i2a_out_if.source        out_o
);
  import i2a_pkg::*;

  i2a_cmd_t    cmd;
  i2a_status_t status;
  logic        in_ready;
  logic        out_valid;
  i2a_out_t    out_data;

  // sequencer
  i2a_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath
  i2a_datapath #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_i.payload),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .out_data_o  (out_data)
  );

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid;
  assign out_o.payload = out_data;

endmodule

>>> verif/tb_integer_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_formatter: self-checking bench of the ASCII formatter
// Feeds numbers with random sign, base, width and pad choices through the
// request channel, predicts every character of each formatted field and
// checks the character channel in order. The sender runs in bursts with
// gaps, and the receiver stalls on a rotating pattern. The receiver also
// holds off for long stretches, and the sender pauses for a full drain
// once between the directed and random parts.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_formatter;
  import i2a_pkg::*;

  localparam int unsigned BufferBytes = 24;
  localparam int unsigned CharLimit   = BufferBytes - 1;
  localparam int unsigned RandItems   = 250;
  localparam int unsigned LongHold    = 600;
  localparam int unsigned EndLatency  = 300;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned MaxPrinted  = 100;

  logic clk_i;
  logic rst_ni;

  i2a_in_if  in_if ();
  i2a_out_if out_if ();

  integer_to_ascii_formatter #(
    .BUFFER_BYTES(BufferBytes)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  i2a_in_t     pending_reqs[$];   // requests not yet offered
  i2a_out_t    exp_chars[$];      // characters still owed by the block
  bit          offering;          // a request is on the channel, not yet taken
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned sent_cnt;
  int unsigned hold_left;
  int unsigned hold_at;
  logic [15:0] stall_pat;
  int unsigned pat_age;
  int unsigned err_cnt   = 0;
  int unsigned cycle_cnt = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  // print one line per mismatch and count it
  task automatic report_mismatch(input string what);
    err_cnt++;
    if (err_cnt <= MaxPrinted) $display("[%0d] mismatch: %s", cycle_cnt, what);
  endtask

  // expected characters of one formatted field
  function automatic void format_chars(input i2a_in_t req);
    logic [63:0] mag;
    logic [3:0]  d;
    logic [7:0]  text[$];
    logic [7:0]  pad_c;
    bit          neg;
    int unsigned len, total, pads, body, emitted;
    i2a_out_t    ch;
    neg = req.signed_mode && req.value[63];
    mag = neg ? -req.value : req.value;
    // digits least significant first, pushed to the front
    do begin
      if (req.hex_mode) begin
        d   = mag[3:0];
        mag = mag >> 4;
      end else begin
        d   = 4'(mag % 10);
        mag = mag / 10;
      end
      text.push_front(d < 4'd10 ? CharZero + 8'(d) : CharLowA + 8'(d) - 8'd10);
    end while (mag != 0);
    if (neg) text.push_front(CharMinus);
    len   = text.size();
    total = (len > req.pad_width) ? len : req.pad_width;
    pads  = (req.pad_width > len) ? req.pad_width - len : 0;
    if (pads > CharLimit) pads = CharLimit;
    // padding goes first, digits get cut after it
    body    = (len > CharLimit - pads) ? CharLimit - pads : len;
    emitted = pads + body;
    pad_c   = req.pad_with_zero ? CharZero : CharSpace;
    for (int unsigned k = 0; k < emitted; k++) begin
      ch.out_char     = (k < pads) ? pad_c : text[k - pads];
      ch.last_char    = (k + 1 == emitted);
      ch.field_length = ch.last_char ? total[7:0] : 8'd0;
      exp_chars.push_back(ch);
    end
  endfunction

  function automatic void add_req(input logic [63:0] v, input logic sgn, input logic hex,
                                  input logic [7:0] width, input logic zero);
    i2a_in_t req;
    req.value         = v;
    req.signed_mode   = sgn;
    req.hex_mode      = hex;
    req.pad_width     = width;
    req.pad_with_zero = zero;
    pending_reqs.push_back(req);
  endfunction

  function automatic i2a_in_t random_request();
    i2a_in_t     req;
    logic [63:0] p;
    case ($urandom_range(0, 6))
      0: req.value = 64'($urandom_range(0, 99));
      1: req.value = {$urandom, $urandom};
      2: req.value = {$urandom, $urandom} >> $urandom_range(1, 63);
      3: req.value = -(64'($urandom_range(1, 5000)));
      4: req.value = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
      5: begin
        // around powers of ten, where the digit count changes
        p = 64'd1;
        repeat ($urandom_range(0, 19)) p = p * 10;
        req.value = p - 64'($urandom_range(0, 1));
      end
      default: req.value = {$urandom | 32'h8000_0000, $urandom};
    endcase
    req.signed_mode   = 1'($urandom);
    req.hex_mode      = 1'($urandom);
    req.pad_width     = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(0, 24));
    req.pad_with_zero = 1'($urandom);
    return req;
  endfunction

  // sender: bursts of requests with random gaps
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    logic    nxt_valid;
    i2a_in_t nxt_req;
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.payload <= '0;
      sent_cnt      <= 0;
      offering   = 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      nxt_valid = in_if.valid;
      nxt_req   = in_if.payload;
      if (in_if.valid && in_if.ready) begin
        format_chars(in_if.payload);
        sent_cnt <= sent_cnt + 1;
        offering  = 1'b0;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0) begin
          nxt_req   = pending_reqs.pop_front();
          nxt_valid = 1'b1;
          offering  = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 6);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
          end
        end
      end
      in_if.valid   <= nxt_valid;
      in_if.payload <= nxt_req;
    end
  end

  // long receiver hold-off, so the block fills up and stalls its input
  always @(posedge clk_i or negedge rst_ni) begin : hold_proc
    if (!rst_ni) begin
      hold_left <= 0;
      hold_at   <= 40;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (sent_cnt >= hold_at) begin
      hold_left <= LongHold;
      hold_at   <= hold_at + 130;
    end
  end

  // receiver: rotating stall pattern, re-picked now and then
  always @(posedge clk_i or negedge rst_ni) begin : sink_proc
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_pat    <= '1;
      pat_age      <= 0;
    end else begin
      if (pat_age == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pat <= '1;
          1:       stall_pat <= 16'($urandom) | 16'h1;
          default: stall_pat <= 16'($urandom & $urandom) | 16'h1;
        endcase
        pat_age <= $urandom_range(20, 120);
      end else begin
        stall_pat <= {stall_pat[0], stall_pat[15:1]};
        pat_age   <= pat_age - 1;
      end
      out_if.ready <= stall_pat[0] && (hold_left == 0);
    end
  end

  // checker: each character against the oldest expectation
  always @(posedge clk_i) begin : check_proc
    i2a_out_t got;
    i2a_out_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.payload;
      if (exp_chars.size() == 0) begin
        report_mismatch($sformatf("char %h with nothing pending", got.out_char));
      end else begin
        want = exp_chars.pop_front();
        if (got.out_char != want.out_char)
          report_mismatch($sformatf("out_char got %h expected %h",
                                    got.out_char, want.out_char));
        if (got.last_char != want.last_char)
          report_mismatch($sformatf("last_char got %b expected %b",
                                    got.last_char, want.last_char));
        if (got.field_length != want.field_length)
          report_mismatch($sformatf("field_length got %0d expected %0d",
                                    got.field_length, want.field_length));
      end
    end
  end

  task automatic wait_drain();
    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || offering || exp_chars.size() != 0);
  endtask

  initial begin : timeout_proc
    wait (cycle_cnt >= CycleLimit);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : main_proc
    rst_ni = 1'b0;

    // directed: extremes, bases, signs, padding and truncation
    add_req(64'd0, 1'b0, 1'b0, 8'd0, 1'b0);
    add_req(64'd0, 1'b1, 1'b1, 8'd0, 1'b1);
    add_req('1, 1'b0, 1'b0, 8'd0, 1'b0);              // 20 decimal digits
    add_req('1, 1'b0, 1'b1, 8'd0, 1'b0);
    add_req('1, 1'b1, 1'b0, 8'd0, 1'b0);              // minus one
    add_req(64'h8000_0000_0000_0000, 1'b1, 1'b0, 8'd0, 1'b0);  // most negative
    add_req(64'h8000_0000_0000_0000, 1'b1, 1'b1, 8'd0, 1'b0);
    add_req(64'h8000_0000_0000_0000, 1'b0, 1'b0, 8'd0, 1'b0);
    add_req(64'h7fff_ffff_ffff_ffff, 1'b1, 1'b0, 8'd0, 1'b0);
    add_req(-64'd42, 1'b1, 1'b0, 8'd8, 1'b1);         // zeros before the sign
    add_req(-64'd255, 1'b1, 1'b1, 8'd6, 1'b0);        // signed hex
    add_req(64'd123, 1'b0, 1'b0, 8'd10, 1'b0);
    add_req(64'hdead_beef, 1'b0, 1'b1, 8'd12, 1'b1);
    add_req(64'h00ab_cdef, 1'b1, 1'b1, 8'd1, 1'b0);
    add_req('1, 1'b0, 1'b0, 8'd23, 1'b1);             // exactly fills the buffer
    add_req('1, 1'b0, 1'b0, 8'd25, 1'b0);             // digits cut off
    add_req(64'd7, 1'b0, 1'b0, 8'd255, 1'b1);         // padding only
    add_req(-64'd9, 1'b1, 1'b0, 8'd255, 1'b0);
    add_req(64'h8000_0000_0000_0000, 1'b1, 1'b0, 8'd22, 1'b1);
    add_req('1, 1'b1, 1'b0, 8'd24, 1'b1);             // sign kept, digit dropped
    add_req(64'd9, 1'b0, 1'b0, 8'd128, 1'b0);
    add_req(64'd10, 1'b0, 1'b0, 8'd2, 1'b0);
    add_req(64'hf, 1'b0, 1'b1, 8'd1, 1'b1);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sender pauses until every directed character has come back
    wait_drain();
    repeat (20) @(posedge clk_i);

    for (int n = 0; n < RandItems; n++) pending_reqs.push_back(random_request());
    wait_drain();
    repeat (EndLatency) @(posedge clk_i);

    if (err_cnt == 0) $display("TB_OK");
    else              $display("TB_ERROR");
    $finish;
  end

endmodule
